@@ design/bectok_pkg.sv @@
// shared types, constants and helpers for the brace escape code tokenizer
package bectok_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int OUT_OFFSET_BITS = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] OPEN_BRACE = 8'h7B;
    localparam logic [7:0] CLOSE_BRACE = 8'h7D;
    localparam logic [7:0] DIGIT_LOW = 8'h30;
    localparam logic [7:0] DIGIT_HIGH = 8'h39;
    localparam logic [1:0] MAX_DIGITS = 2'd3;
    localparam logic [9:0] MAX_CODE = 10'd255;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_BRACE   = 2'd1,
        MODE_CODE    = 2'd2,
        MODE_SWALLOW = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_CODE  = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                        kind;
        logic [7:0]                   value;
        logic [OUT_OFFSET_BITS-1:0]   offset;
        logic                         run_end;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     slot0;
        t_token     slot1;
    } t_push;

    function automatic logic [OUT_OFFSET_BITS-1:0] cap_offset(
        input logic [OFFSET_BITS-1:0] v
    );
        logic [31:0] w;
        w = 32'(v);
        cap_offset = (w > 32'h0000_FFFF) ? 16'hFFFF : w[OUT_OFFSET_BITS-1:0];
    endfunction

endpackage

@@ design/brace_escape_code_tokenizer_unit.sv @@
// brace escape code tokenizer: text bytes in, character/code/error/end tokens out
// a byte's tokens are queued when its beat is taken and offered from the queue head
// throughput: one byte per cycle while m_tready stays high and each byte gives
//   at most one token; a byte giving two tokens (code, character or error, then end) queues both
// queue of four tokens between scanner and output; s_tready drops when fewer than two free
// reset: synchronous active low, clears scanner state and empties the queue
module brace_escape_code_tokenizer_unit
    import bectok_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // token_value [7:0], token_offset [23:8]
    output logic        m_tlast,   // run_end
    output logic [1:0]  m_tuser    // token_kind
);

    logic   fire;
    logic   room;
    t_push  push;
    t_token head;

    assign s_tready = room;
    assign fire = s_tvalid && room;

    bectok_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (s_tdata),
        .i_last  (s_tlast),
        .o_push  (push)
    );

    bectok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_tvalid),
        .o_token (head),
        .i_pop   (m_tready)
    );

    assign m_tdata = {head.offset, head.value};
    assign m_tlast = head.run_end;
    assign m_tuser = head.kind;

endmodule

@@ design/bectok_scan.sv @@
// scanner state and token generation for one text byte per beat
module bectok_scan
    import bectok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_push      o_push
);

    t_mode                  r_mode, n_mode;
    logic [1:0]             r_digits, n_digits;
    logic [9:0]             r_acc, n_acc;
    logic [OFFSET_BITS-1:0] r_byte_off, n_byte_off;
    logic [OFFSET_BITS-1:0] r_brace_off, n_brace_off;

    logic       is_digit;
    logic [3:0] dval;
    logic       e0_v;
    t_token     e0;
    t_token     ea;
    t_token     end_tok;
    logic       a_v;
    logic [OFFSET_BITS-1:0] off_inc;
    t_mode      step_mode;
    logic [OFFSET_BITS-1:0] step_brace;

    assign is_digit = i_byte inside {[DIGIT_LOW:DIGIT_HIGH]};
    assign dval = 4'(i_byte - DIGIT_LOW);
    assign off_inc = (r_byte_off == '1) ? r_byte_off : r_byte_off + 1'b1;

    // per-byte step
    always_comb begin
        step_mode = r_mode;
        step_brace = r_brace_off;
        n_digits = r_digits;
        n_acc = r_acc;
        e0_v = 1'b0;
        e0 = '{kind: KIND_CHAR, value: i_byte, offset: cap_offset(r_byte_off), run_end: 1'b0};
        case (r_mode)
            MODE_PLAIN: begin
                if (i_byte == OPEN_BRACE) begin
                    step_brace = r_byte_off;
                    step_mode = MODE_BRACE;
                end else begin
                    e0_v = 1'b1;
                end
            end
            MODE_BRACE: begin
                if (i_byte == OPEN_BRACE) begin
                    e0_v = 1'b1;
                    e0.value = OPEN_BRACE;
                    e0.offset = cap_offset(r_brace_off);
                    step_mode = MODE_PLAIN;
                end else if (is_digit) begin
                    n_acc = {6'd0, dval};
                    n_digits = 2'd1;
                    step_mode = MODE_CODE;
                end else begin
                    e0_v = 1'b1;
                    e0 = '{kind: KIND_ERROR, value: 8'd0,
                           offset: cap_offset(r_brace_off), run_end: 1'b0};
                    step_mode = MODE_SWALLOW;
                end
            end
            MODE_CODE: begin
                if (i_byte == CLOSE_BRACE) begin
                    e0_v = 1'b1;
                    if (r_acc <= MAX_CODE) begin
                        e0 = '{kind: KIND_CODE, value: r_acc[7:0],
                               offset: cap_offset(r_brace_off), run_end: 1'b0};
                        step_mode = MODE_PLAIN;
                    end else begin
                        e0 = '{kind: KIND_ERROR, value: 8'd0,
                               offset: cap_offset(r_brace_off), run_end: 1'b0};
                        step_mode = MODE_SWALLOW;
                    end
                end else if (is_digit && r_digits < MAX_DIGITS) begin
                    n_acc = 10'(r_acc * 10'd10) + {6'd0, dval};
                    n_digits = r_digits + 2'd1;
                end else begin
                    e0_v = 1'b1;
                    e0 = '{kind: KIND_ERROR, value: 8'd0,
                           offset: cap_offset(r_brace_off), run_end: 1'b0};
                    step_mode = MODE_SWALLOW;
                end
            end
            default: begin
            end
        endcase
    end

    // end of text handling and result slots
    always_comb begin
        a_v = e0_v;
        ea = e0;
        end_tok = '{kind: KIND_END, value: 8'd0, offset: cap_offset(off_inc), run_end: 1'b1};
        if (!e0_v && i_last && (step_mode == MODE_BRACE || step_mode == MODE_CODE)) begin
            a_v = 1'b1;
            ea = '{kind: KIND_ERROR, value: 8'd0,
                   offset: cap_offset(step_brace), run_end: 1'b0};
        end
        o_push.slot1 = end_tok;
        if (i_last) begin
            o_push.count = a_v ? 2'd2 : 2'd1;
            o_push.slot0 = a_v ? ea : end_tok;
        end else begin
            o_push.count = a_v ? 2'd1 : 2'd0;
            o_push.slot0 = ea;
            o_push.slot0.run_end = 1'b1;
        end
        if (!i_fire) begin
            o_push.count = 2'd0;
        end
    end

    always_comb begin
        n_mode = step_mode;
        n_brace_off = step_brace;
        n_byte_off = off_inc;
        if (i_last) begin
            n_mode = MODE_PLAIN;
            n_brace_off = '0;
            n_byte_off = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_digits <= 2'd0;
            r_acc <= 10'd0;
            r_byte_off <= '0;
            r_brace_off <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_digits <= i_last ? 2'd0 : n_digits;
            r_acc <= i_last ? 10'd0 : n_acc;
            r_byte_off <= n_byte_off;
            r_brace_off <= n_brace_off;
        end
    end

endmodule

@@ design/bectok_fifo.sv @@
// small token queue taking up to two tokens per beat
module bectok_fifo
    import bectok_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_room,
    output logic   o_valid,
    output t_token o_token,
    input  logic   i_pop
);

    t_token                   r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr, n_wr;
    logic [FIFO_PTR_BITS-1:0] r_rd, n_rd;
    logic [FIFO_CNT_BITS-1:0] r_cnt, n_cnt;
    logic                     pop;
    logic [FIFO_PTR_BITS-1:0] wr1;

    assign o_valid = (r_cnt != '0);
    assign o_token = r_mem[r_rd];
    assign o_room = (r_cnt <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
    assign pop = i_pop && o_valid;
    assign wr1 = r_wr + 1'b1;

    always_comb begin
        n_wr = r_wr + FIFO_PTR_BITS'(i_push.count);
        n_rd = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + FIFO_CNT_BITS'(i_push.count) - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr1] <= i_push.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ dv/brace_escape_code_tokenizer_unit_tb.sv @@
// self-checking testbench for the brace escape code tokenizer unit
`timescale 1ns / 100ps

module brace_escape_code_tokenizer_unit_tb
    import bectok_pkg::*;
();

    typedef logic [7:0] t_text_q[$];

    class token_scoreboard;
        t_mode                  mode;
        logic [1:0]             ndigits;
        logic [9:0]             code_acc;
        logic [OFFSET_BITS-1:0] next_pos;
        logic [OFFSET_BITS-1:0] brace_pos;
        t_token                 expected_q[$];
        int                     fails;

        function new();
            restart();
            fails = 0;
        endfunction

        function void restart();
            mode      = MODE_PLAIN;
            ndigits   = 2'd0;
            code_acc  = 10'd0;
            next_pos  = '0;
            brace_pos = '0;
        endfunction

        function t_token make_token(t_kind k, logic [7:0] v, logic [OFFSET_BITS-1:0] off);
            t_token t;
            t.kind    = k;
            t.value   = v;
            t.offset  = (32'(off) > 32'h0000_FFFF) ? 16'hFFFF : off[OUT_OFFSET_BITS-1:0];
            t.run_end = 1'b0;
            return t;
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            t_token                 toks[2];
            int                     n;
            logic [OFFSET_BITS-1:0] pos;
            logic                   is_digit;
            n = 0;
            pos = next_pos;
            is_digit = (b >= DIGIT_LOW) && (b <= DIGIT_HIGH);
            case (mode)
                MODE_PLAIN: begin
                    if (b == OPEN_BRACE) begin
                        brace_pos = pos;
                        mode = MODE_BRACE;
                    end else begin
                        toks[n] = make_token(KIND_CHAR, b, pos);
                        n = n + 1;
                    end
                end
                MODE_BRACE: begin
                    if (b == OPEN_BRACE) begin
                        toks[n] = make_token(KIND_CHAR, OPEN_BRACE, brace_pos);
                        n = n + 1;
                        mode = MODE_PLAIN;
                    end else if (is_digit) begin
                        code_acc = 10'(b - DIGIT_LOW);
                        ndigits = 2'd1;
                        mode = MODE_CODE;
                    end else begin
                        toks[n] = make_token(KIND_ERROR, 8'd0, brace_pos);
                        n = n + 1;
                        mode = MODE_SWALLOW;
                    end
                end
                MODE_CODE: begin
                    if (b == CLOSE_BRACE) begin
                        if (code_acc <= MAX_CODE) begin
                            toks[n] = make_token(KIND_CODE, code_acc[7:0], brace_pos);
                            n = n + 1;
                            mode = MODE_PLAIN;
                        end else begin
                            toks[n] = make_token(KIND_ERROR, 8'd0, brace_pos);
                            n = n + 1;
                            mode = MODE_SWALLOW;
                        end
                    end else if (is_digit && ndigits < MAX_DIGITS) begin
                        code_acc = 10'(code_acc * 10 + 10'(b - DIGIT_LOW));
                        ndigits = ndigits + 2'd1;
                    end else begin
                        toks[n] = make_token(KIND_ERROR, 8'd0, brace_pos);
                        n = n + 1;
                        mode = MODE_SWALLOW;
                    end
                end
                default: ;
            endcase
            if (next_pos != '1)
                next_pos = next_pos + 1'b1;
            if (fin) begin
                if (mode == MODE_BRACE || mode == MODE_CODE) begin
                    toks[n] = make_token(KIND_ERROR, 8'd0, brace_pos);
                    n = n + 1;
                end
                toks[n] = make_token(KIND_END, 8'd0, next_pos);
                n = n + 1;
                restart();
            end
            if (n > 0)
                toks[n-1].run_end = 1'b1;
            for (int i = 0; i < n; i++)
                expected_q.push_back(toks[i]);
        endfunction

        task report(string msg);
            fails++;
            if (fails <= 40)
                $display("[%0t] token error: %s", $realtime, msg);
        endtask

        task check_token(logic [1:0] kind, logic [7:0] value, logic [15:0] offset, logic last);
            t_token want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected beat kind %0d value %0h offset %0d",
                    kind, value, offset));
                return;
            end
            want = expected_q.pop_front();
            if (kind !== want.kind)
                report($sformatf("kind %0d, want %0d", kind, want.kind));
            if (value !== want.value)
                report($sformatf("value %0h, want %0h", value, want.value));
            if (offset !== want.offset)
                report($sformatf("offset %0d, want %0d", offset, want.offset));
            if (last !== want.run_end)
                report($sformatf("run end %0b, want %0b", last, want.run_end));
        endtask
    endclass

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    token_scoreboard sb;
    int              beats_in;
    int              stall_cycles;
    int              hold_left;
    logic            calm;
    logic            hold_req;
    logic            held;

    brace_escape_code_tokenizer_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!calm && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        sb.note_byte(b, fin);
        beats_in++;
    endtask

    task automatic send_text(input t_text_q txt);
        for (int i = 0; i < txt.size(); i++)
            send_byte(txt[i], i == txt.size() - 1);
    endtask

    // output side: checks each token taken, random stalls, one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_token(m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast);
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (hold_req && !held) begin
                held <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("brace_escape_code_tokenizer_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        t_text_q    txt;
        int         rand_items;
        int         ntok;
        int         r;
        int         m;
        int         nd;
        int         val;
        int         len;
        logic [7:0] c;
        logic       stop;

        sb = new();
        beats_in = 0;
        stall_cycles = 0;
        hold_left = 0;
        held = 1'b0;
        hold_req = 1'b0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tlast = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // byte extremes, literal brace, smallest and largest code
        send_text('{8'h00, 8'hFF, OPEN_BRACE, OPEN_BRACE, OPEN_BRACE, 8'h30, CLOSE_BRACE,
            OPEN_BRACE, 8'h32, 8'h35, 8'h35, CLOSE_BRACE, 8'h5A});
        // empty code
        send_text('{OPEN_BRACE, CLOSE_BRACE});
        // value above the limit, closing brace ends the text
        send_text('{OPEN_BRACE, 8'h32, 8'h35, 8'h36, CLOSE_BRACE});
        // non-digit inside a code, then swallowed bytes
        send_text('{OPEN_BRACE, 8'h31, 8'h61, 8'h37, CLOSE_BRACE});
        // fourth digit
        send_text('{OPEN_BRACE, 8'h31, 8'h32, 8'h33, 8'h34});
        // text ends inside a code, then on a lone brace
        send_text('{OPEN_BRACE, 8'h39, 8'h39});
        send_text('{OPEN_BRACE});

        rand_items = 0;
        while (rand_items < 920) begin
            txt = {};
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(5);
                    if (r == 0)
                        txt.push_back(OPEN_BRACE);
                    else if (r == 1)
                        txt.push_back(CLOSE_BRACE);
                    else if (r == 2)
                        txt.push_back(8'($urandom_range(DIGIT_LOW, DIGIT_HIGH)));
                    else
                        txt.push_back(8'($urandom_range(255)));
                end
            end else begin
                ntok = $urandom_range(1, 10);
                stop = 1'b0;
                for (int k = 0; k < ntok && !stop; k++) begin
                    r = $urandom_range(99);
                    if (r < 55) begin
                        c = 8'($urandom_range(255));
                        txt.push_back(c == OPEN_BRACE ? 8'h7C : c);
                    end else if (r < 67) begin
                        txt.push_back(OPEN_BRACE);
                        txt.push_back(OPEN_BRACE);
                    end else if (r < 92 || (r >= 92 && $urandom_range(4) == 3)) begin
                        m = (r < 92) ? 5 : 3;
                        val = (m == 5) ? $urandom_range(255) : $urandom_range(256, 999);
                        nd = (val > 99) ? 3 : (val > 9) ? 2 : 1;
                        nd = $urandom_range(nd, 3);
                        txt.push_back(OPEN_BRACE);
                        if (nd == 3)
                            txt.push_back(8'(DIGIT_LOW + val / 100));
                        if (nd >= 2)
                            txt.push_back(8'(DIGIT_LOW + (val / 10) % 10));
                        txt.push_back(8'(DIGIT_LOW + val % 10));
                        txt.push_back(CLOSE_BRACE);
                    end else begin
                        m = $urandom_range(3);
                        txt.push_back(OPEN_BRACE);
                        if (m == 0) begin
                            txt.push_back(CLOSE_BRACE);
                        end else if (m == 1) begin
                            if ($urandom_range(1))
                                txt.push_back(8'($urandom_range(DIGIT_LOW, DIGIT_HIGH)));
                            do
                                c = 8'($urandom_range(255));
                            while ((c >= DIGIT_LOW && c <= DIGIT_HIGH) || c == CLOSE_BRACE);
                            txt.push_back(c);
                        end else if (m == 2) begin
                            repeat (4)
                                txt.push_back(8'($urandom_range(DIGIT_LOW, DIGIT_HIGH)));
                        end else begin
                            repeat ($urandom_range(3))
                                txt.push_back(8'($urandom_range(DIGIT_LOW, DIGIT_HIGH)));
                            stop = 1'b1;
                        end
                    end
                end
            end
            send_text(txt);
            rand_items += txt.size();
            if (rand_items >= 250)
                hold_req <= 1'b1;
            calm <= (rand_items >= 500 && rand_items < 700);
        end
        s_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.fails == 0)
            $display("brace_escape_code_tokenizer_unit: match");
        else
            $display("brace_escape_code_tokenizer_unit: mismatch");
        $finish;
    end

endmodule
